>>> rtl/tmt_pkg.sv
`timescale 1ns / 1ps

package tmt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIST_W    = 24;
    localparam int SPEED_W   = 20;
    localparam int ACCEL_W   = 26;
    localparam int TIME_W    = 32;
    localparam int ADDR_W    = 3;

    localparam int SQ_W    = 2 * SPEED_W;
    localparam int AD_W    = ACCEL_W + DIST_W;
    localparam int TWOAD_W = AD_W + 1;
    // square root input is kept an even number of bits wide
    localparam int ROOT_W  = (TWOAD_W + 2) / 2;
    localparam int SUM_W   = 2 * ROOT_W;
    localparam int NUM_W   = SUM_W;
    localparam int AM_W    = ACCEL_W + SPEED_W;
    localparam int DEN_W   = AM_W + 1;
    localparam int SUB_W   = SPEED_W + 1;
    localparam int RREM_W  = ROOT_W + 2;
    localparam int DIVW    = NUM_W + FRAC_BITS;
    localparam int HI_W    = DIVW - TIME_W;

    // front stages, root stages, post stage, divider entry, quotient bits
    localparam int LATENCY = 3 + ROOT_W + 2 + TIME_W;

    typedef enum logic [1:0] {
        CASE_ACCEL = 2'd0,
        CASE_DECEL = 2'd1,
        CASE_TRAP  = 2'd2,
        CASE_TRI   = 2'd3
    } t_case;

    typedef enum logic {
        REG_ACCEL = 1'b0,
        REG_SPEED = 1'b1
    } t_reg;

    typedef struct packed {
        t_case              pcase;
        logic [SUB_W-1:0]   sub;
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
    } t_sq_pay;

    typedef struct packed {
        logic               vld;
        logic [SUM_W-1:0]   arg;
        t_sq_pay            pay;
    } t_sq_in;

    typedef struct packed {
        logic               vld;
        logic [ROOT_W-1:0]  root;
        t_sq_pay            pay;
    } t_sq_out;

    typedef struct packed {
        logic               vld;
        t_case              pcase;
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
    } t_div_in;

endpackage

>>> rtl/tmt_front.sv
`timescale 1ns / 1ps

module tmt_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [tmt_pkg::DIST_W-1:0]    i_dist,
    input  logic [tmt_pkg::SPEED_W-1:0]   i_u,
    input  logic [tmt_pkg::SPEED_W-1:0]   i_w,
    input  logic [tmt_pkg::ACCEL_W-1:0]   i_a,
    input  logic [tmt_pkg::SPEED_W-1:0]   i_m,
    output tmt_pkg::t_sq_in               o_sq
);

    localparam int SQ_W  = tmt_pkg::SQ_W;
    localparam int AD_W  = tmt_pkg::AD_W;
    localparam int AM_W  = tmt_pkg::AM_W;
    localparam int SUM_W = tmt_pkg::SUM_W;
    localparam int DEN_W = tmt_pkg::DEN_W;
    localparam int SUB_W = tmt_pkg::SUB_W;

    logic [tmt_pkg::SPEED_W-1:0] du, dw;

    logic                        r1_vld;
    logic [SQ_W-1:0]             r1_uu, r1_ww, r1_mm, r1_du2, r1_dw2;
    logic [AD_W-1:0]             r1_ad;
    logic [AM_W-1:0]             r1_am;
    logic [tmt_pkg::SPEED_W-1:0] r1_u, r1_w;
    logic [tmt_pkg::ACCEL_W-1:0] r1_a;

    logic                        r2_vld;
    logic [SUM_W-1:0]            r2_sum_u, r2_sum_w, r2_tot, r2_c2num;
    logic [SQ_W:0]               r2_mm2;
    logic [SQ_W-1:0]             r2_uu, r2_ww;
    logic [DEN_W-1:0]            r2_am2;
    logic [tmt_pkg::SPEED_W-1:0] r2_u, r2_w;
    logic [tmt_pkg::ACCEL_W-1:0] r2_a;

    tmt_pkg::t_sq_in r_sq, n_sq;
    logic c0, c1, c2;

    assign du = (i_m > i_u) ? i_m - i_u : i_u - i_m;
    assign dw = (i_m > i_w) ? i_m - i_w : i_w - i_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r_sq.vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r_sq.vld <= n_sq.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_uu  <= SQ_W'(i_u) * SQ_W'(i_u);
        r1_ww  <= SQ_W'(i_w) * SQ_W'(i_w);
        r1_mm  <= SQ_W'(i_m) * SQ_W'(i_m);
        r1_du2 <= SQ_W'(du) * SQ_W'(du);
        r1_dw2 <= SQ_W'(dw) * SQ_W'(dw);
        r1_ad  <= AD_W'(i_a) * AD_W'(i_dist);
        r1_am  <= AM_W'(i_a) * AM_W'(i_m);
        r1_u   <= i_u;
        r1_w   <= i_w;
        r1_a   <= i_a;

        r2_sum_u <= SUM_W'(r1_uu) + SUM_W'({r1_ad, 1'b0});
        r2_sum_w <= SUM_W'(r1_ww) + SUM_W'({r1_ad, 1'b0});
        r2_tot   <= SUM_W'({r1_ad, 1'b0}) + SUM_W'(r1_uu) + SUM_W'(r1_ww);
        r2_c2num <= SUM_W'({r1_ad, 1'b0}) + SUM_W'(r1_du2) + SUM_W'(r1_dw2);
        r2_mm2   <= {r1_mm, 1'b0};
        r2_uu    <= r1_uu;
        r2_ww    <= r1_ww;
        r2_am2   <= {r1_am, 1'b0};
        r2_u     <= r1_u;
        r2_w     <= r1_w;
        r2_a     <= r1_a;

        r_sq.arg <= n_sq.arg;
        r_sq.pay <= n_sq.pay;
    end

    // case decision, first match wins
    always_comb begin
        c0 = SUM_W'(r2_ww) >= r2_sum_u;
        c1 = SUM_W'(r2_uu) >= r2_sum_w;
        c2 = SUM_W'(r2_mm2) < r2_tot;
        n_sq.vld     = r2_vld;
        n_sq.pay.num = r2_c2num;
        n_sq.pay.den = DEN_W'(r2_a);
        if (c0) begin
            n_sq.pay.pcase = tmt_pkg::CASE_ACCEL;
            n_sq.pay.sub   = SUB_W'(r2_u);
            n_sq.arg       = r2_sum_u;
        end else if (c1) begin
            n_sq.pay.pcase = tmt_pkg::CASE_DECEL;
            n_sq.pay.sub   = SUB_W'(r2_w);
            n_sq.arg       = r2_sum_w;
        end else if (c2) begin
            n_sq.pay.pcase = tmt_pkg::CASE_TRAP;
            n_sq.pay.sub   = '0;
            n_sq.arg       = '0;
            n_sq.pay.den   = r2_am2;
        end else begin
            n_sq.pay.pcase = tmt_pkg::CASE_TRI;
            n_sq.pay.sub   = SUB_W'(r2_u) + SUB_W'(r2_w);
            n_sq.arg       = r2_tot >> 1;
        end
    end

    assign o_sq = r_sq;

endmodule

>>> rtl/tmt_isqrt.sv
`timescale 1ns / 1ps

module tmt_isqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tmt_pkg::t_sq_in   i_sq,
    output tmt_pkg::t_sq_out  o_sq
);

    localparam int ROOT_W = tmt_pkg::ROOT_W;
    localparam int SUM_W  = tmt_pkg::SUM_W;
    localparam int RREM_W = tmt_pkg::RREM_W;

    logic              r_vld  [ROOT_W];
    logic [RREM_W-1:0] r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SUM_W-1:0]  r_arg  [ROOT_W];
    tmt_pkg::t_sq_pay  r_pay  [ROOT_W];

    logic              n_vld  [ROOT_W];
    logic [RREM_W-1:0] n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];
    logic [SUM_W-1:0]  n_arg  [ROOT_W];
    tmt_pkg::t_sq_pay  n_pay  [ROOT_W];

    // one root bit per stage, two argument bits shifted in each time
    always_comb begin
        logic [RREM_W+1:0] rem2;
        logic [RREM_W+1:0] trial;
        logic [RREM_W-1:0] rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SUM_W-1:0]  arg_in;
        for (int k = 0; k < ROOT_W; k++) begin
            if (k == 0) begin
                n_vld[k] = i_sq.vld;
                n_pay[k] = i_sq.pay;
                rem_in   = '0;
                root_in  = '0;
                arg_in   = i_sq.arg;
            end else begin
                n_vld[k] = r_vld[k-1];
                n_pay[k] = r_pay[k-1];
                rem_in   = r_rem[k-1];
                root_in  = r_root[k-1];
                arg_in   = r_arg[k-1];
            end
            rem2  = {rem_in, arg_in[SUM_W-1 -: 2]};
            trial = {{(RREM_W-ROOT_W){1'b0}}, root_in, 2'b01};
            if (rem2 >= trial) begin
                n_rem[k]  = RREM_W'(rem2 - trial);
                n_root[k] = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = rem2[RREM_W-1:0];
                n_root[k] = {root_in[ROOT_W-2:0], 1'b0};
            end
            n_arg[k] = arg_in << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ROOT_W; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= n_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ROOT_W; k++) begin
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
            r_arg[k]  <= n_arg[k];
            r_pay[k]  <= n_pay[k];
        end
    end

    assign o_sq.vld  = r_vld[ROOT_W-1];
    assign o_sq.root = r_root[ROOT_W-1];
    assign o_sq.pay  = r_pay[ROOT_W-1];

endmodule

>>> rtl/tmt_div.sv
`timescale 1ns / 1ps

module tmt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tmt_pkg::t_div_in            i_div,
    output logic                        o_vld,
    output logic [tmt_pkg::TIME_W-1:0]  o_time,
    output tmt_pkg::t_case              o_case
);

    localparam int TIME_W = tmt_pkg::TIME_W;
    localparam int DEN_W  = tmt_pkg::DEN_W;
    localparam int DIVW   = tmt_pkg::DIVW;
    localparam int HI_W   = tmt_pkg::HI_W;
    localparam int NST    = TIME_W + 1;

    logic              r_vld [NST];
    logic [DEN_W-1:0]  r_rem [NST];
    logic [DEN_W-1:0]  r_den [NST];
    logic [TIME_W-1:0] r_lo  [NST];
    logic [TIME_W-1:0] r_q   [NST];
    logic              r_sat [NST];
    tmt_pkg::t_case    r_case[NST];

    logic              n_vld [NST];
    logic [DEN_W-1:0]  n_rem [NST];
    logic [DEN_W-1:0]  n_den [NST];
    logic [TIME_W-1:0] n_lo  [NST];
    logic [TIME_W-1:0] n_q   [NST];
    logic              n_sat [NST];
    tmt_pkg::t_case    n_case[NST];

    // entry stage checks for quotient overflow, then one quotient bit per stage
    always_comb begin
        logic [DIVW-1:0]  wide;
        logic [DEN_W-1:0] hi;
        logic [DEN_W:0]   r2;
        logic [DEN_W:0]   dx;
        wide = {i_div.num, {tmt_pkg::FRAC_BITS{1'b0}}};
        hi   = {{(DEN_W-HI_W){1'b0}}, wide[DIVW-1:TIME_W]};
        n_vld[0]  = i_div.vld;
        n_den[0]  = i_div.den;
        n_case[0] = i_div.pcase;
        n_sat[0]  = hi >= i_div.den;
        n_rem[0]  = (hi >= i_div.den) ? '0 : hi;
        n_lo[0]   = wide[TIME_W-1:0];
        n_q[0]    = '0;
        for (int k = 1; k < NST; k++) begin
            r2 = {r_rem[k-1], r_lo[k-1][TIME_W-1]};
            dx = {1'b0, r_den[k-1]};
            n_vld[k]  = r_vld[k-1];
            n_den[k]  = r_den[k-1];
            n_case[k] = r_case[k-1];
            n_sat[k]  = r_sat[k-1];
            n_lo[k]   = r_lo[k-1] << 1;
            if (r2 >= dx) begin
                n_rem[k] = DEN_W'(r2 - dx);
                n_q[k]   = {r_q[k-1][TIME_W-2:0], 1'b1};
            end else begin
                n_rem[k] = r2[DEN_W-1:0];
                n_q[k]   = {r_q[k-1][TIME_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= n_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            r_rem[k]  <= n_rem[k];
            r_den[k]  <= n_den[k];
            r_lo[k]   <= n_lo[k];
            r_q[k]    <= n_q[k];
            r_sat[k]  <= n_sat[k];
            r_case[k] <= n_case[k];
        end
    end

    assign o_vld  = r_vld[NST-1];
    assign o_time = r_sat[NST-1] ? '1 : r_q[NST-1];
    assign o_case = r_case[NST-1];

endmodule

>>> rtl/trapezoid_move_time_top.sv
`timescale 1ns / 1ps
// throughput: one query per cycle; busy is always low, every stage advances each cycle
// 3 front stages (squares, sums, case select), 26 root stages, 1 post stage,
// 1 divider entry stage and 32 quotient stages, one bit per stage
// reset: synchronous active low, clears the valid bits and loads the register defaults
// results are presented for one cycle only; the receiver cannot stall
module trapezoid_move_time_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [tmt_pkg::DIST_W-1:0]          i_move_distance,
    input  logic [tmt_pkg::SPEED_W-1:0]         i_start_speed,
    input  logic [tmt_pkg::SPEED_W-1:0]         i_end_speed,
    output logic                                o_done,
    output logic [tmt_pkg::TIME_W-1:0]          o_move_time,
    output logic [1:0]                          o_profile_case,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tmt_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int ACCEL_W = tmt_pkg::ACCEL_W;
    localparam int SPEED_W = tmt_pkg::SPEED_W;
    localparam int ROOT_W  = tmt_pkg::ROOT_W;
    localparam int NUM_W   = tmt_pkg::NUM_W;

    logic [ACCEL_W-1:0] r_accel;
    logic [SPEED_W-1:0] r_speed;
    logic [ACCEL_W-1:0] a_eff;
    logic [SPEED_W-1:0] m_eff;
    tmt_pkg::t_reg      reg_sel;

    tmt_pkg::t_sq_in    sq_in;
    tmt_pkg::t_sq_out   sq_out;
    tmt_pkg::t_div_in   r_post, n_post;
    tmt_pkg::t_case     out_case;
    logic [ROOT_W:0]    root_x;

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign reg_sel = tmt_pkg::t_reg'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel <= ACCEL_W'(983040);
            r_speed <= SPEED_W'(262144);
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                tmt_pkg::REG_ACCEL: r_accel <= pwdata[ACCEL_W-1:0];
                tmt_pkg::REG_SPEED: r_speed <= pwdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            tmt_pkg::REG_ACCEL: prdata = 32'(r_accel);
            tmt_pkg::REG_SPEED: prdata = 32'(r_speed);
            default:            prdata = '0;
        endcase
    end

    // a zero limit acts as the smallest step
    assign a_eff = (r_accel == '0) ? ACCEL_W'(1) : r_accel;
    assign m_eff = (r_speed == '0) ? SPEED_W'(1) : r_speed;

    tmt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_dist  (i_move_distance),
        .i_u     (i_start_speed),
        .i_w     (i_end_speed),
        .i_a     (a_eff),
        .i_m     (m_eff),
        .o_sq    (sq_in)
    );

    tmt_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sq    (sq_in),
        .o_sq    (sq_out)
    );

    // numerator for the divider: root minus speeds, or the trapezoid sum
    always_comb begin
        root_x = (sq_out.pay.pcase == tmt_pkg::CASE_TRI) ? {sq_out.root, 1'b0}
                                                         : {1'b0, sq_out.root};
        n_post.vld   = sq_out.vld;
        n_post.pcase = sq_out.pay.pcase;
        n_post.den   = sq_out.pay.den;
        if (sq_out.pay.pcase == tmt_pkg::CASE_TRAP) begin
            n_post.num = sq_out.pay.num;
        end else begin
            n_post.num = NUM_W'(root_x) - NUM_W'(sq_out.pay.sub);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_post.vld <= 1'b0;
        end else begin
            r_post.vld <= n_post.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_post.pcase <= n_post.pcase;
        r_post.num   <= n_post.num;
        r_post.den   <= n_post.den;
    end

    tmt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_div   (r_post),
        .o_vld   (o_done),
        .o_time  (o_move_time),
        .o_case  (out_case)
    );

    assign o_profile_case = out_case;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && i_rst_n, tmt_pkg::LATENCY))
        else $error("result strobe without a transfer at the pipeline latency");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    a_root_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_post.vld && r_post.pcase != tmt_pkg::CASE_TRAP)
            |-> ((r_post.num >> (ROOT_W + 1)) == '0))
        else $error("root minus speed went negative");

endmodule

>>> test/tb_trapezoid_move_time_top.sv
`timescale 1ns / 1ps

module tb_trapezoid_move_time_top;
    import tmt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PER_PHASE   = 105;

    typedef struct {
        logic [TIME_W-1:0] move_time;
        t_case             pcase;
    } t_timing;

    typedef struct {
        logic [DIST_W-1:0]  move_dist;
        logic [SPEED_W-1:0] v0;
        logic [SPEED_W-1:0] v1;
        bit                 known;
        logic [TIME_W-1:0]  move_time;
        t_case              pcase;
    } t_query_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [DIST_W-1:0]    i_move_distance;
    logic [SPEED_W-1:0]   i_start_speed;
    logic [SPEED_W-1:0]   i_end_speed;
    logic                 o_done;
    logic [TIME_W-1:0]    o_move_time;
    logic [1:0]           o_profile_case;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    logic [ACCEL_W-1:0]   accel_lim;
    logic [SPEED_W-1:0]   top_speed;
    t_timing              pending_times[$];
    t_query_row           typed_rows[$];
    int                   error_count;
    int                   cycle_count;
    bit                   allow_gaps;

    trapezoid_move_time_top uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] floor_root(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'h1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // floor(n * 2^16 / den), clipped to the time width
    function automatic logic [TIME_W-1:0] scaled_quot(logic [63:0] n, logic [63:0] den);
        logic [127:0] q;
        q = ({64'd0, n} << FRAC_BITS) / {64'd0, den};
        if (q > 128'hFFFF_FFFF) return '1;
        return q[TIME_W-1:0];
    endfunction

    function automatic t_timing travel_time(logic [DIST_W-1:0] move_dist,
                                            logic [SPEED_W-1:0] v0,
                                            logic [SPEED_W-1:0] v1);
        t_timing     r;
        logic [63:0] a, m, d, u, w, uu, ww, two_ad, du, dw, s;
        a = (accel_lim == 0) ? 64'd1 : 64'(accel_lim);
        m = (top_speed == 0) ? 64'd1 : 64'(top_speed);
        d = 64'(move_dist);
        u = 64'(v0);
        w = 64'(v1);
        uu = u * u;
        ww = w * w;
        two_ad = 2 * a * d;
        if (ww >= uu && ww - uu >= two_ad) begin
            r.move_time = scaled_quot(floor_root(uu + two_ad) - u, a);
            r.pcase = CASE_ACCEL;
        end else if (uu >= ww && uu - ww >= two_ad) begin
            r.move_time = scaled_quot(floor_root(ww + two_ad) - w, a);
            r.pcase = CASE_DECEL;
        end else if ($signed(2 * m * m) - $signed(uu) - $signed(ww) < $signed(two_ad)) begin
            du = (m > u) ? m - u : u - m;
            dw = (m > w) ? m - w : w - m;
            r.move_time = scaled_quot(two_ad + du * du + dw * dw, 2 * a * m);
            r.pcase = CASE_TRAP;
        end else begin
            s = floor_root((two_ad + uu + ww) >> 1);
            r.move_time = scaled_quot(2 * s - u - w, a);
            r.pcase = CASE_TRI;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_timing    got;
        t_query_row row;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n && start && !busy)
            pending_times.push_back(travel_time(i_move_distance, i_start_speed, i_end_speed));
        if (i_rst_n && o_done) begin
            if (pending_times.size() == 0) begin
                $error("unexpected result transfer: move_time %0h", o_move_time);
                error_count++;
            end else begin
                got = pending_times.pop_front();
                if (typed_rows.size() != 0) begin
                    row = typed_rows.pop_front();
                    if (row.known) begin
                        got.move_time = row.move_time;
                        got.pcase     = row.pcase;
                    end
                end
                if (o_move_time !== got.move_time) begin
                    $error("move_time expected %0h actual %0h", got.move_time, o_move_time);
                    error_count++;
                end
                if (o_profile_case !== got.pcase) begin
                    $error("profile_case expected %0d actual %0d", got.pcase, o_profile_case);
                    error_count++;
                end
            end
        end
    end

    task automatic write_reg(t_reg idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_ACCEL) accel_lim = value[ACCEL_W-1:0];
        else top_speed = value[SPEED_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // called at a clock edge; returns at the edge that accepts the transfer
    task automatic send_query(t_query_row row);
        if (allow_gaps && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_move_distance <= row.move_dist;
        i_start_speed   <= row.v0;
        i_end_speed     <= row.v1;
        do @(posedge i_clk); while (busy);
        typed_rows.push_back(row);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_times.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        logic [DIST_W-1:0]  move_dist;
        logic [SPEED_W-1:0] v0, v1;
        t_query_row         row;
        repeat (n) begin
            move_dist = DIST_W'($urandom);
            v0        = SPEED_W'($urandom);
            v1        = SPEED_W'($urandom);
            case ($urandom_range(0, 4))
                0: move_dist = DIST_W'($urandom_range(0, 255));
                1: move_dist = move_dist >> $urandom_range(0, 23);
                2: begin
                    v0 = SPEED_W'(top_speed - $urandom_range(0, 64));
                    v1 = top_speed >> $urandom_range(0, 4);
                end
                default: ;
            endcase
            row = '{move_dist, v0, v1, 1'b0, 32'd0, CASE_ACCEL};
            send_query(row);
        end
    endtask

    t_query_row directed[] = '{
        '{24'd0, 20'd0, 20'd0, 1'b1, 32'd0, CASE_ACCEL},
        '{24'd0, 20'd5000, 20'd5000, 1'b1, 32'd0, CASE_ACCEL},
        '{24'd0, 20'hFFFFF, 20'hFFFFF, 1'b1, 32'd0, CASE_ACCEL},
        '{24'd0, 20'd7000, 20'd0, 1'b1, 32'd0, CASE_DECEL},
        '{24'd1, 20'd0, 20'hFFFFF, 1'b0, 32'd0, CASE_ACCEL},
        '{24'd1, 20'hFFFFF, 20'd0, 1'b0, 32'd0, CASE_ACCEL},
        '{24'hFFFFFF, 20'd0, 20'd0, 1'b0, 32'd0, CASE_ACCEL},
        '{24'hFFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b0, 32'd0, CASE_ACCEL},
        '{24'h010000, 20'd0, 20'd0, 1'b0, 32'd0, CASE_ACCEL},
        '{24'h001000, 20'h10000, 20'h08000, 1'b0, 32'd0, CASE_ACCEL},
        '{24'h000100, 20'h40000, 20'h40000, 1'b0, 32'd0, CASE_ACCEL},
        '{24'h080000, 20'h50000, 20'h60000, 1'b0, 32'd0, CASE_ACCEL},
        '{24'h000040, 20'h20000, 20'h20100, 1'b0, 32'd0, CASE_ACCEL},
        '{24'h5A5A5A, 20'hA5A5A, 20'h5A5A5, 1'b0, 32'd0, CASE_ACCEL}
    };

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_move_distance = '0;
        i_start_speed = '0;
        i_end_speed = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        cycle_count = 0;
        allow_gaps = 1'b1;
        accel_lim = 26'd983040;
        top_speed = 20'd262144;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_query(directed[k]);
        end
        random_phase(PER_PHASE);
        drain();

        // zero limits act as the smallest step; large times clip
        write_reg(REG_ACCEL, 32'd0);
        write_reg(REG_SPEED, 32'd0);
        send_query('{24'hFFFFFF, 20'd0, 20'd0, 1'b0, 32'd0, CASE_ACCEL});
        send_query('{24'hFFFFFF, 20'hFFFFF, 20'd0, 1'b0, 32'd0, CASE_ACCEL});
        random_phase(PER_PHASE);
        drain();

        write_reg(REG_ACCEL, 32'h3FFFFFF);
        write_reg(REG_SPEED, 32'hFFFFF);
        random_phase(PER_PHASE);
        drain();

        write_reg(REG_ACCEL, 32'd1);
        write_reg(REG_SPEED, 32'd1);
        random_phase(PER_PHASE);
        drain();

        write_reg(REG_ACCEL, $urandom_range(1, 32'h3FFFFFF));
        write_reg(REG_SPEED, $urandom_range(1, 32'hFFFFF));
        random_phase(PER_PHASE);
        drain();

        allow_gaps = 1'b0;
        write_reg(REG_ACCEL, 32'd983040);
        write_reg(REG_SPEED, 32'd262144);
        random_phase(PER_PHASE);
        drain();

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/tmt_pkg.sv
rtl/tmt_front.sv
rtl/tmt_isqrt.sv
rtl/tmt_div.sv
rtl/trapezoid_move_time_top.sv
test/tb_trapezoid_move_time_top.sv
